// ===== hw/rtl/mesi_lru_cache_controller_core_assert.svh =====
// Assertion macros for the MESI LRU cache controller checker
`ifndef MESI_LRU_CACHE_CONTROLLER_CORE_ASSERT_SVH
`define MESI_LRU_CACHE_CONTROLLER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define MLC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mlc assertion failed");

// Implication checked in the cycle after the antecedent
`define MLC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mlc assertion failed");

`endif

// ===== hw/rtl/mlc_pkg.sv =====
// Shared types and constants for the MESI LRU cache controller
package mlc_pkg;

  localparam int CmdW = 3;
  localparam int AddrW = 32;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_FILL_R = 3'd2,
    CMD_FILL_W = 3'd3,
    CMD_UPDATE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_IGNORED = 3'd1,
    ST_MISS    = 3'd2,
    ST_UPGRADE = 3'd3,
    ST_FILLED  = 3'd4,
    ST_UPDATED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_RDX  = 2'd2,
    BUS_UPGR = 2'd3
  } bus_e;

  typedef enum logic [1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_EXEC  = 2'd2,
    BK_CLEAR = 2'd3
  } bk_state_e;

  // Classified request passed from front to back
  typedef struct packed {
    logic             ignore;
    logic [CmdW-1:0]  cmd;
    logic [AddrW-1:0] addr;
    logic [1:0]       new_state;
  } req_t;

endpackage

// ===== hw/rtl/mlc_front.sv =====
// Front end: accepts items, classifies ignored ones, two-entry queue to the back
module mlc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      command_i,
  input  logic [31:0]     address_i,
  input  logic            core_busy_i,
  input  logic [1:0]      new_state_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output mlc_pkg::req_t   q_req_o
);
  import mlc_pkg::*;

  req_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  req_t       req;
  logic       push, pop;

  // Access commands are ignored when busy; unknown commands always
  always_comb begin
    req.cmd       = command_i;
    req.addr      = address_i;
    req.new_state = new_state_i;
    req.ignore    = (command_i > CMD_UPDATE) ||
                    (core_busy_i && (command_i == CMD_READ || command_i == CMD_WRITE));
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_req_o    = fifo_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= req;
  end

endmodule

// ===== hw/rtl/mlc_back.sv =====
// Back end: set memory read-modify-write, hit/fill/update logic, result register
module mlc_back #(
  parameter int SET_BITS    = 6,
  parameter int WAYS        = 2,
  parameter int OFFSET_BITS = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  mlc_pkg::req_t q_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [1:0]    bus_request_o,
  output logic          way_used_o,
  output logic          evicted_o,
  output logic          writeback_o,
  output logic [31:0]   writeback_address_o,
  output logic          stall_res_o
);
  import mlc_pkg::*;

  localparam int NSets = 1 << SET_BITS;
  localparam int TagW  = 32 - SET_BITS - OFFSET_BITS;
  localparam int WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  // One memory row holds a whole set: per way tag, state, dirty, rank
  localparam int EntW  = TagW + 2 + 1 + WayW;
  localparam int RowW  = EntW * WAYS;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [1:0]      st;
    logic            dirty;
    logic [WayW-1:0] rank;
  } ent_t;

  logic [RowW-1:0]     mem_q [NSets];
  logic [RowW-1:0]     rd_q;
  logic [SET_BITS-1:0] clr_q;
  bk_state_e           state_q, state_d;
  req_t                req_q;
  logic                mem_we;
  logic [SET_BITS-1:0] mem_wa;
  logic [RowW-1:0]     mem_wd, rst_row, new_row;

  logic                ovalid_q;
  logic [2:0]          status_q, status_d;
  logic [1:0]          bus_q, bus_d;
  logic                way_q, way_d, ev_q, ev_d, wb_q, wb_d, stall_q, stall_d;
  logic [31:0]         wba_q, wba_d;

  ent_t                ent [WAYS];
  ent_t                nent [WAYS];
  logic [SET_BITS-1:0] set_idx;
  logic [TagW-1:0]     tag;
  logic                hit_found, inv_found, lru_found;
  logic [WayW-1:0]     hit_w, inv_w, lru_w, vic_w, mru_w;
  logic                do_mru;
  logic [WayW-1:0]     mru_r;
  logic [WayW:0]       way_full;

  assign set_idx = req_q.addr[OFFSET_BITS +: SET_BITS];
  assign tag     = req_q.addr[31 -: TagW];

  // Reset row: invalid, clean, rank equals way number
  always_comb begin
    ent_t e;
    rst_row = '0;
    for (int w = 0; w < WAYS; w++) begin
      e       = '0;
      e.rank  = WayW'(w);
      rst_row[w*EntW +: EntW] = e;
    end
  end

  // Way search over the registered row
  always_comb begin
    hit_found = 1'b0; inv_found = 1'b0; lru_found = 1'b0;
    hit_w = '0; inv_w = '0; lru_w = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent[w] = rd_q[w*EntW +: EntW];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (ent[w].st != MESI_I && ent[w].tag == tag) begin
        hit_found = 1'b1; hit_w = WayW'(w);
      end
      if (ent[w].st == MESI_I) begin
        inv_found = 1'b1; inv_w = WayW'(w);
      end
      if (ent[w].rank == '0) begin
        lru_found = 1'b1; lru_w = WayW'(w);
      end
    end
  end

  // Execute: compute result and new row
  always_comb begin
    status_d = ST_IGNORED; bus_d = BUS_NONE; way_full = '0;
    ev_d = 1'b0; wb_d = 1'b0; wba_d = '0; stall_d = 1'b0;
    do_mru = 1'b0; mru_w = '0; vic_w = '0;
    for (int w = 0; w < WAYS; w++) nent[w] = ent[w];
    if (!req_q.ignore) begin
      case (req_q.cmd)
        CMD_READ, CMD_WRITE: begin
          if (!hit_found) begin
            status_d = ST_MISS;
            bus_d    = (req_q.cmd == CMD_READ) ? BUS_RD : BUS_RDX;
            stall_d  = 1'b1;
          end else begin
            way_full = (WayW + 1)'(hit_w);
            if (req_q.cmd == CMD_READ) begin
              status_d = ST_HIT; do_mru = 1'b1; mru_w = hit_w;
            end else if (ent[hit_w].st == MESI_E || ent[hit_w].st == MESI_M) begin
              status_d = ST_HIT; do_mru = 1'b1; mru_w = hit_w;
              nent[hit_w].dirty = 1'b1;
              nent[hit_w].st    = MESI_M;
            end else begin
              status_d = ST_UPGRADE; bus_d = BUS_UPGR;
            end
          end
        end
        CMD_FILL_R, CMD_FILL_W: begin
          if (inv_found) begin
            vic_w = inv_w;
          end else begin
            vic_w = lru_found ? lru_w : '0;
            ev_d  = 1'b1;
            if (ent[vic_w].dirty) begin
              wb_d    = 1'b1;
              wba_d   = {ent[vic_w].tag, set_idx, {OFFSET_BITS{1'b0}}};
              stall_d = (req_q.cmd == CMD_FILL_R);
            end
          end
          nent[vic_w].tag   = tag;
          nent[vic_w].dirty = (req_q.cmd == CMD_FILL_W);
          nent[vic_w].st    = req_q.new_state;
          do_mru   = 1'b1; mru_w = vic_w;
          status_d = ST_FILLED;
          way_full = (WayW + 1)'(vic_w);
        end
        CMD_UPDATE: begin
          status_d = ST_UPDATED;
          if (hit_found) begin
            nent[hit_w].st = req_q.new_state;
            way_full       = (WayW + 1)'(hit_w);
          end
        end
        default: ;
      endcase
    end
    way_d = way_full[0];
    // LRU refresh: lines above the touched rank move down one
    mru_r = ent[mru_w].rank;
    if (do_mru) begin
      for (int w = 0; w < WAYS; w++) begin
        if (ent[w].rank > mru_r) nent[w].rank = ent[w].rank - WayW'(1);
      end
      nent[mru_w].rank = WayW'(WAYS - 1);
    end
    for (int w = 0; w < WAYS; w++) new_row[w*EntW +: EntW] = nent[w];
  end

  // Sequencer: clear sweep, read, execute
  always_comb begin
    state_d   = state_q;
    q_ready_o = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = set_idx;
    mem_wd    = new_row;
    case (state_q)
      BK_CLEAR: begin
        mem_we = 1'b1; mem_wa = clr_q; mem_wd = rst_row;
        if (clr_q == SET_BITS'(NSets - 1)) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        q_ready_o = !ovalid_q || out_ready_i;
        if (q_valid_i && q_ready_o) state_d = BK_READ;
      end
      BK_READ: state_d = BK_EXEC;
      BK_EXEC: begin
        mem_we  = 1'b1;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) clr_q <= clr_q + SET_BITS'(1);
      if (state_q == BK_EXEC) ovalid_q <= 1'b1;
      else if (out_ready_i)   ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) req_q <= q_req_i;
    if (state_q == BK_READ) rd_q <= mem_q[set_idx];
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (state_q == BK_EXEC) begin
      status_q <= status_d; bus_q <= bus_d; way_q <= way_d;
      ev_q <= ev_d; wb_q <= wb_d; wba_q <= wba_d; stall_q <= stall_d;
    end
  end

  assign out_valid_o         = ovalid_q;
  assign status_o            = status_q;
  assign bus_request_o       = bus_q;
  assign way_used_o          = way_q;
  assign evicted_o           = ev_q;
  assign writeback_o         = wb_q;
  assign writeback_address_o = wba_q;
  assign stall_res_o         = stall_q;

endmodule

// ===== hw/rtl/mesi_lru_cache_controller_core.sv =====
// Top level of the MESI LRU cache controller core
// The back end takes one item at a time and steps it through set read, register,
// execute and write back, set by the single-port set memory's read-modify-write; a
// two-entry queue lets the front take items meanwhile. After reset the back
// end clears all 2**SET_BITS sets of the set memory before executing items.
module mesi_lru_cache_controller_core #(
  parameter int SET_BITS    = 6,
  parameter int WAYS        = 2,
  parameter int OFFSET_BITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] address_i,
  input  logic        core_busy_i,
  input  logic [1:0]  new_state_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  bus_request_o,
  output logic        way_used_o,
  output logic        evicted_o,
  output logic        writeback_o,
  output logic [31:0] writeback_address_o,
  output logic        stall_res_o
);
  import mlc_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  mlc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .address_i,
    .core_busy_i, .new_state_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  mlc_back #(
    .SET_BITS(SET_BITS), .WAYS(WAYS), .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .status_o, .bus_request_o, .way_used_o,
    .evicted_o, .writeback_o, .writeback_address_o, .stall_res_o
  );

endmodule

// ===== hw/rtl/mlc_checker.sv =====
// Port-level checker for the MESI LRU cache controller core, with its bind
`include "mesi_lru_cache_controller_core_assert.svh"

module mlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [1:0]  bus_request_o,
  input logic        evicted_o,
  input logic        writeback_o,
  input logic [31:0] writeback_address_o
);
  import mlc_pkg::*;

  // A stalled result holds
  `MLC_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(status_o))
  // Writeback only comes with an eviction
  `MLC_ASSERT_IMP(a_wb_ev, clk_i, rst_ni, out_valid_o && writeback_o, evicted_o)
  // Evictions only on fills
  `MLC_ASSERT_IMP(a_ev_fill, clk_i, rst_ni, out_valid_o && evicted_o, status_o == ST_FILLED)
  // Bus requests only on misses and upgrades
  `MLC_ASSERT_IMP(a_bus, clk_i, rst_ni, out_valid_o && bus_request_o != BUS_NONE,
    status_o == ST_MISS || status_o == ST_UPGRADE)

endmodule

bind mesi_lru_cache_controller_core mlc_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .status_o, .bus_request_o,
  .evicted_o, .writeback_o, .writeback_address_o
);
